// File: rtl/bb5_pkg.sv
// ============================================================================
// bb5_pkg: shared types and constants for the 5x5 box blur stream
// Register codes, request codes, sizes and the divide-by-25 reciprocal.
// ============================================================================
package bb5_pkg;

    localparam int PIX_W  = 8;
    localparam int LINE_W = 4 * PIX_W;

    // Configuration port
    localparam int CFG_DW = 11;
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 1'b1;

    // Request kinds carried in tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int MIN_SIZE   = 12;
    localparam int RST_WIDTH  = 891;
    localparam int RST_HEIGHT = 893;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Window sums: 5 * 255 per column, 25 * 255 for the window
    localparam int COL_SUM_W = 11;
    localparam int SUM_W     = 13;

    // floor(x / 25) == (x * 5243) >> 17 for every x below 25 * 256
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_MW    = 13;
    localparam int DIV25_SHIFT = 17;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/bb5_divider.sv
// ============================================================================
// bb5_divider: restoring divider, one quotient bit per cycle
// Splits the output count into row and column after a size change.
// ============================================================================
module bb5_divider import bb5_pkg::*; #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        // The partial remainder stays below the divisor, so it fits DEN_W bits.
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

// File: rtl/box_blur_5x5_stream.sv
// ============================================================================
// box_blur_5x5_stream: 5x5 box blur on a raster stream of 8-bit grey pixels
// A result beat passes through the Stage B registers, the Stage C registers
// and the output queue. The input takes one beat per cycle while the queue
// has room; after a configuration write it is held off while the output row
// and column are rebuilt by the serial divider.
// Reset (synchronous, active low) clears positions, window sums and queue;
// the line store is not cleared and is read only where it has been written.
// ============================================================================
module box_blur_5x5_stream import bb5_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration writes
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic              s_axis_tuser,   // [0] req_type
    // Output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [PIX_W-1:0]  m_axis_tdata,   // [7:0] pixel_out
    output logic              m_axis_tuser,   // [0] was_blurred
    output logic              m_axis_tlast    // last_of_frame
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PW   = CNTW + 2;
    localparam int CW1  = WW + 1;
    localparam int SWW  = (WW > CFG_DW) ? WW : CFG_DW;
    localparam int SHW  = (HW > CFG_DW) ? HW : CFG_DW;
    localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_H = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
    localparam int PRODW = SUM_W + DIV25_MW;

    typedef struct packed {
        logic             last;
        logic             blur;
        logic [PIX_W-1:0] pix;
    } t_res;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    logic [WW-1:0]    r_w;
    logic [HW-1:0]    r_h;
    logic             r_cfg_pend;
    logic [NW-1:0]    r_total;
    logic [SWW-1:0]   cfg_w_ext;
    logic [SHW-1:0]   cfg_h_ext;
    logic [WW-1:0]    sat_w;
    logic [HW-1:0]    sat_h;
    logic [WW+HW-1:0] total_prod;

    always_comb begin
        cfg_w_ext = SWW'(i_cfg_data);
        cfg_h_ext = SHW'(i_cfg_data);
        if (cfg_w_ext < SWW'(MIN_SIZE)) begin
            sat_w = WW'(MIN_SIZE);
        end else if (cfg_w_ext > SWW'(MAX_WIDTH)) begin
            sat_w = WW'(MAX_WIDTH);
        end else begin
            sat_w = WW'(cfg_w_ext);
        end
        if (cfg_h_ext < SHW'(MIN_SIZE)) begin
            sat_h = HW'(MIN_SIZE);
        end else if (cfg_h_ext > SHW'(MAX_HEIGHT)) begin
            sat_h = HW'(MAX_HEIGHT);
        end else begin
            sat_h = HW'(cfg_h_ext);
        end
        total_prod = (WW+HW)'(r_w) * (WW+HW)'(r_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= WW'(RST_W);
            r_h        <= HW'(RST_H);
            r_cfg_pend <= 1'b0;
            r_total    <= NW'(RST_W * RST_H);
        end else begin
            r_cfg_pend <= i_cfg_we;
            r_total    <= NW'(total_prod);
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_WIDTH:  r_w <= sat_w;
                    CFG_HEIGHT: r_h <= sat_h;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output position rebuild after a size change
    // ------------------------------------------------------------------------
    t_div_stat        div_stat;
    logic [CNTW-1:0]  div_quo;
    logic [WW-1:0]    div_rem;
    logic [CNTW-1:0]  r_cnt;
    logic             busy_all;

    bb5_divider #(
        .NUM_W (CNTW),
        .DEN_W (WW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cfg_pend),
        .i_num   (r_cnt),
        .i_den   (r_w),
        .o_stat  (div_stat),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign busy_all = r_cfg_pend | div_stat.busy | div_stat.done;

    // ------------------------------------------------------------------------
    // Stage A: position bookkeeping and line store read
    // ------------------------------------------------------------------------
    logic [CW-1:0]  r_in_col;
    logic [HW-1:0]  r_in_row;
    logic [CNTW-1:0] r_pr;
    logic [CW-1:0]  r_pc;

    logic [FIFO_CW-1:0] r_f_cnt;
    logic               r_b_valid;
    logic               r_b_emit;
    logic               r_c_valid;
    logic [FIFO_CW:0]   cred;
    logic               accept;

    logic            is_pixel;
    logic            is_flush;
    logic            row_done;
    logic            col_over;
    logic [HW-1:0]   row_a;
    logic [CW-1:0]   col_a;
    logic            wrap_end;
    logic            pixel_go;
    logic            pix_emit;
    logic            flush_go;
    logic            emit;
    logic [WW-1:0]   col_nx;
    logic            col_wrap;
    logic [WW-1:0]   pc_nx;
    logic            pc_wrap;
    logic            interior;
    logic [NW:0]     cnt_inc;
    logic            is_last;
    logic [PW-1:0]   pr_t;
    logic [PW-1:0]   h_ext;
    logic [PW-1:0]   k_diff;
    logic [1:0]      k_sel;
    logic [CW-1:0]   rd_addr;

    always_comb begin
        is_pixel = (s_axis_tuser == REQ_PIXEL);
        is_flush = (s_axis_tuser == REQ_FLUSH);
        row_done = (r_in_row >= r_h);
        col_over = (WW'(r_in_col) >= r_w);
        row_a    = col_over ? HW'(r_in_row + 1'b1) : r_in_row;
        col_a    = col_over ? '0 : r_in_col;
        // A column left over past a shrunk width moves on to the next row.
        wrap_end = is_pixel && !row_done && col_over && (row_a >= r_h);
        pixel_go = is_pixel && !row_done && !wrap_end;
        // Results start with the pixel that follows the first 2 * width + 2 of the frame.
        pix_emit = (row_a > HW'(2)) || ((row_a == HW'(2)) && (col_a >= CW'(2)));
        flush_go = is_flush && row_done;
        emit     = (pixel_go && pix_emit) || flush_go;

        col_nx   = WW'(col_a) + 1'b1;
        col_wrap = (col_nx >= r_w);
        pc_nx    = WW'(r_pc) + 1'b1;
        pc_wrap  = (pc_nx >= r_w);

        interior = (r_pc >= CW'(6)) && ((CW1'(r_pc) + CW1'(6)) <= CW1'(r_w))
                && (r_pr >= CNTW'(5)) && ((PW'(r_pr) + PW'(6)) <= PW'(r_h));

        cnt_inc = (NW+1)'(r_cnt) + 1'b1;
        is_last = (cnt_inc >= (NW+1)'(r_total));

        // Flush results read the stored row that matches the output row.
        pr_t   = PW'(r_pr) + PW'(4);
        h_ext  = PW'(r_h);
        k_diff = pr_t - h_ext;
        if (pr_t < h_ext) begin
            k_sel = 2'd0;
        end else if (k_diff > PW'(3)) begin
            k_sel = 2'd3;
        end else begin
            k_sel = k_diff[1:0];
        end

        rd_addr = is_flush ? r_pc : col_a;

        cred = (FIFO_CW+1)'(r_f_cnt) + (FIFO_CW+1)'(r_b_valid && r_b_emit)
             + (FIFO_CW+1)'(r_c_valid);
    end

    assign s_axis_tready = !busy_all && !i_cfg_we && (cred < (FIFO_CW+1)'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_cnt    <= '0;
            r_pr     <= '0;
            r_pc     <= '0;
        end else if (div_stat.done) begin
            r_pr <= div_quo;
            r_pc <= div_rem[CW-1:0];
        end else if (accept) begin
            if (pixel_go) begin
                r_in_col <= col_wrap ? '0 : col_nx[CW-1:0];
                r_in_row <= col_wrap ? HW'(row_a + 1'b1) : row_a;
            end else if (wrap_end) begin
                r_in_col <= '0;
                r_in_row <= row_a;
            end
            if (emit) begin
                if (is_last) begin
                    r_in_col <= '0;
                    r_in_row <= '0;
                    r_cnt    <= '0;
                    r_pr     <= '0;
                    r_pc     <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    if (pc_wrap) begin
                        r_pc <= '0;
                        r_pr <= r_pr + 1'b1;
                    end else begin
                        r_pc <= pc_nx[CW-1:0];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Line store: four older rows per column, oldest in the low byte
    // ------------------------------------------------------------------------
    logic [LINE_W-1:0] r_line [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;

    logic              r_b_flush;
    logic [CW-1:0]     r_b_col;
    logic [PIX_W-1:0]  r_b_pix;
    logic              r_b_row0;
    logic [1:0]        r_b_k;
    logic              r_b_blur;
    logic              r_b_last;

    logic [LINE_W-1:0] old_raw;
    logic [LINE_W-1:0] old;
    logic [LINE_W-1:0] b_wdata;
    logic              b_wr;

    always_ff @(posedge i_clk) begin
        if (b_wr) begin
            r_line[r_b_col] <= b_wdata;
        end
        if (accept) begin
            r_rd <= r_line[rd_addr];
        end
    end

    // A read in the same cycle as the write to that column takes the new word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd      <= b_wr && (r_b_col == rd_addr);
            r_fwd_data <= b_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept && (pixel_go || flush_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_flush <= flush_go;
            r_b_emit  <= emit;
            r_b_col   <= col_a;
            r_b_pix   <= s_axis_tdata;
            r_b_row0  <= (row_a == '0);
            r_b_k     <= k_sel;
            r_b_blur  <= pixel_go && interior;
            r_b_last  <= is_last;
        end
    end

    // ------------------------------------------------------------------------
    // Stage B: window update, running window sum, line store write
    // ------------------------------------------------------------------------
    logic [COL_SUM_W-1:0] r_cs [5];
    logic [SUM_W-1:0]     r_sum;
    logic [PIX_W-1:0]     r_mid [2];
    logic [COL_SUM_W-1:0] col_sum;
    logic [SUM_W-1:0]     sum_nx;
    logic [PIX_W-1:0]     flush_byte;
    logic                 b_pix;

    always_comb begin
        old_raw = r_fwd ? r_fwd_data : r_rd;
        // The first row of a frame sees zeros above it.
        old     = r_b_row0 ? '0 : old_raw;
        b_wdata = {r_b_pix, old[LINE_W-1:PIX_W]};
        b_pix   = r_b_valid && !r_b_flush;
        b_wr    = b_pix;
        col_sum = COL_SUM_W'(old[7:0]) + COL_SUM_W'(old[15:8])
                + COL_SUM_W'(old[23:16]) + COL_SUM_W'(old[31:24])
                + COL_SUM_W'(r_b_pix);
        sum_nx  = r_sum - SUM_W'(r_cs[0]) + SUM_W'(col_sum);
        case (r_b_k)
            2'd0:    flush_byte = old_raw[7:0];
            2'd1:    flush_byte = old_raw[15:8];
            2'd2:    flush_byte = old_raw[23:16];
            default: flush_byte = old_raw[31:24];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_cs[i] <= '0;
            end
            r_sum    <= '0;
            r_mid[0] <= '0;
            r_mid[1] <= '0;
        end else if (b_pix) begin
            for (int i = 0; i < 4; i++) begin
                r_cs[i] <= r_cs[i+1];
            end
            r_cs[4]  <= col_sum;
            r_sum    <= sum_nx;
            // Row 2 of the window; its centre column is two shifts behind.
            r_mid[0] <= r_mid[1];
            r_mid[1] <= old[23:16];
        end
    end

    logic             r_c_blur;
    logic             r_c_last;
    logic [PIX_W-1:0] r_c_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_blur <= r_b_blur;
            r_c_last <= r_b_last;
            r_c_val  <= r_b_flush ? flush_byte : r_mid[0];
        end
    end

    // ------------------------------------------------------------------------
    // Stage C: divide by 25 and queue the result
    // ------------------------------------------------------------------------
    logic [PRODW-1:0]   prod;
    t_res               c_res;
    t_res               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic               push;
    logic               pop;

    always_comb begin
        prod       = PRODW'(r_sum) * PRODW'(DIV25_MUL);
        c_res.last = r_c_last;
        c_res.blur = r_c_blur;
        c_res.pix  = r_c_blur ? prod[DIV25_SHIFT +: PIX_W] : r_c_val;
        push       = r_c_valid;
        pop        = m_axis_tvalid && m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_f_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_f_cnt <= r_f_cnt + 1'b1;
            end else if (pop && !push) begin
                r_f_cnt <= r_f_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= c_res;
        end
    end

    assign m_axis_tvalid = (r_f_cnt != '0);
    assign m_axis_tdata  = r_fifo[r_rp].pix;
    assign m_axis_tuser  = r_fifo[r_rp].blur;
    assign m_axis_tlast  = r_fifo[r_rp].last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (r_f_cnt != FIFO_CW'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy_all |-> (WW'(r_pc) < r_w))
        else $error("output column outside the row");

    a_sum_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum == (SUM_W'(r_cs[0]) + SUM_W'(r_cs[1]) + SUM_W'(r_cs[2])
                + SUM_W'(r_cs[3]) + SUM_W'(r_cs[4])))
        else $error("window sum out of step with column sums");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit && is_last) |=> ((r_cnt == '0) && (r_in_row == '0)
                                         && (r_in_col == '0)))
        else $error("positions not cleared after the last beat of a frame");

endmodule

// File: sim/tb_box_blur_5x5_stream.sv
// ============================================================================
// tb_box_blur_5x5_stream: self-checking testbench for the 5x5 box blur stream
// Feeds frames of raster pixels and flush beats, predicts each output beat
// with an independent behavioral copy of the filter, and compares field by
// field. Covers minimum and maximum frame sizes, saturated size writes, a
// resize in the middle of a frame, ignored beats, and output backpressure.
// ============================================================================
module tb_box_blur_5x5_stream;
    import bb5_pkg::*;

    localparam int          MAX_W       = 1024;
    localparam int          MAX_H       = 1024;
    localparam int          HALF_PERIOD = 10;
    localparam int          SETTLE      = 8;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          PRINT_CAP   = 25;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pix;
    } pixel_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             blurred;
        logic             last;
    } blur_result_t;

    typedef enum {FILL_RANDOM, FILL_BRIGHT, FILL_BINARY, FILL_DARK} fill_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [PIX_W-1:0]  s_axis_tdata;   // [7:0] pixel_in
    logic              s_axis_tuser;   // [0] req_type
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [PIX_W-1:0]  m_axis_tdata;   // [7:0] pixel_out
    logic              m_axis_tuser;   // [0] was_blurred
    logic              m_axis_tlast;   // last_of_frame

    box_blur_5x5_stream dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Behavioral copy of the filter state.
    logic [CFG_DW-1:0] cfg_width;
    logic [CFG_DW-1:0] cfg_height;
    logic [LINE_W-1:0] line_mem [MAX_W];
    logic [PIX_W-1:0]  win [25];
    int unsigned       pos_col;
    int unsigned       pos_row;
    int unsigned       res_count;

    pixel_beat_t  pending_beats[$];
    blur_result_t expected_pixels[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_reqs;
    int unsigned stall_seen;
    int unsigned stall_left;
    bit          in_taken;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned beats_in;
    int unsigned results_checked;
    int unsigned blurred_seen;
    int unsigned frames_seen;
    int unsigned stim_items;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned fit_size(input logic [CFG_DW-1:0] v, input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic push_result(input logic [PIX_W-1:0] value, input logic blurred,
                               input int unsigned total);
        blur_result_t r;
        r.value   = value;
        r.blurred = blurred;
        r.last    = (res_count + 1 >= total);
        expected_pixels.push_back(r);
        if (r.last) begin
            pos_col   = 0;
            pos_row   = 0;
            res_count = 0;
        end else begin
            res_count++;
        end
    endtask

    // Advances the filter copy by one accepted input beat.
    task automatic blur_predict(input logic kind, input logic [PIX_W-1:0] pix);
        int unsigned w, h, total, n, pr, pc, k, sum;
        logic [LINE_W-1:0] old;
        w     = fit_size(cfg_width, MAX_W);
        h     = fit_size(cfg_height, MAX_H);
        total = w * h;
        if (kind == REQ_PIXEL) begin
            if (pos_row >= h) return;
            // A column left past a shrunken width wraps to the next row.
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row++;
                if (pos_row >= h) return;
            end
            old = (pos_row == 0) ? '0 : line_mem[pos_col];
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 4; c++)
                    win[r*5+c] = win[r*5+c+1];
                win[r*5+4] = (r < 4) ? old[8*r +: 8] : pix;
            end
            line_mem[pos_col] = {pix, old[LINE_W-1:8]};
            n = pos_row * w + pos_col;
            pos_col++;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row++;
            end
            if (n < 2 * w + 2) return;
            pr = res_count / w;
            pc = res_count % w;
            if (pc >= 6 && pc + 6 <= w && pr >= 5 && pr + 6 <= h) begin
                sum = 0;
                for (int i = 0; i < 25; i++) sum += win[i];
                push_result(PIX_W'(sum / 25), 1'b1, total);
            end else begin
                push_result(win[12], 1'b0, total);
            end
        end else begin
            if (pos_row < h) return;
            pr = res_count / w;
            pc = res_count % w;
            // Tail rows come from the store; anything older reads the oldest row.
            k = (pr + 4 < h) ? 0 : pr + 4 - h;
            if (k > 3) k = 3;
            push_result(line_mem[pc][8*k +: 8], 1'b0, total);
        end
    endtask

    // Monitor: input acceptance feeds the predictor, output beats are checked.
    always @(posedge i_clk) begin : monitor
        blur_result_t want;
        cycle_count++;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            beats_in++;
            blur_predict(s_axis_tuser, s_axis_tdata);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("output beat with nothing expected (data %0d)",
                                          m_axis_tdata));
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch($sformatf("result %0d pixel_out %0d, expected %0d",
                                              results_checked, m_axis_tdata, want.value));
                if (m_axis_tuser !== want.blurred)
                    report_mismatch($sformatf("result %0d was_blurred %0b, expected %0b",
                                              results_checked, m_axis_tuser, want.blurred));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("result %0d last_of_frame %0b, expected %0b",
                                              results_checked, m_axis_tlast, want.last));
                if (want.blurred) blurred_seen++;
                if (want.last) frames_seen++;
            end
            results_checked++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, expected_pixels.size());
            $display("tb_box_blur_5x5_stream NOT OK");
            $finish;
        end
    end

    // Driver: holds a beat until it is taken, then offers the next or idles.
    always @(negedge i_clk) begin : driver
        pixel_beat_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_taken || !s_axis_tvalid) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.pix;
                s_axis_tuser  <= nxt.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure, plus a long hold-off on request.
    always @(negedge i_clk) begin : receiver
        if (stall_seen != stall_reqs) begin
            stall_seen = stall_reqs;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(input fill_t fill);
        case (fill)
            FILL_BRIGHT: return PIX_W'(255 - $urandom_range(3));
            FILL_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
            FILL_DARK:   return PIX_W'($urandom_range(15));
            default:     return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic add_beat(input logic kind, input logic [PIX_W-1:0] pix);
        pixel_beat_t b;
        b.kind = kind;
        b.pix  = pix;
        pending_beats.push_back(b);
    endtask

    // Waits until every beat is taken and every result has come back.
    task automatic settle();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_DW-1:0] w_reg, input logic [CFG_DW-1:0] h_reg);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_WIDTH;
        i_cfg_data <= w_reg;
        @(negedge i_clk);
        i_cfg_addr <= CFG_HEIGHT;
        i_cfg_data <= h_reg;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_width  = w_reg;
        cfg_height = h_reg;
    endtask

    // One whole frame at the current size, with some beats the block ignores:
    // flushes among the pixels and pixels among the tail flushes.
    task automatic queue_frame(input int unsigned noise_pct);
        int unsigned w, h;
        fill_t fill;
        w    = fit_size(cfg_width, MAX_W);
        h    = fit_size(cfg_height, MAX_H);
        fill = fill_t'($urandom_range(3));
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < noise_pct) add_beat(REQ_FLUSH, PIX_W'($urandom_range(255)));
            add_beat(REQ_PIXEL, pick_pixel(fill));
        end
        for (int i = 0; i < 2 * w + 2; i++) begin
            if ($urandom_range(99) < noise_pct) add_beat(REQ_PIXEL, PIX_W'($urandom_range(255)));
            add_beat(REQ_FLUSH, PIX_W'($urandom_range(255)));
        end
        stim_items += w * h + 2 * w + 2;
    endtask

    // Completes a frame left open by a resize; the predictor is up to date.
    task automatic finish_frame();
        int unsigned w, h, r, c, left;
        w = fit_size(cfg_width, MAX_W);
        h = fit_size(cfg_height, MAX_H);
        r = pos_row;
        c = pos_col;
        if (c >= w) begin
            c = 0;
            r++;
        end
        left = (r < h) ? (h - r) * w - c : 0;
        repeat (left) add_beat(REQ_PIXEL, pick_pixel(FILL_RANDOM));
        settle();
        left = (w * h > res_count) ? w * h - res_count : 1;
        repeat (left) add_beat(REQ_FLUSH, 8'h00);
        stim_items += left;
    endtask

    initial begin
        int unsigned phase_start;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PIXEL;
        m_axis_tready = 1'b0;
        cfg_width     = RST_WIDTH;
        cfg_height    = RST_HEIGHT;
        pos_col       = 0;
        pos_row       = 0;
        res_count     = 0;
        for (int i = 0; i < 25; i++) win[i] = '0;
        for (int i = 0; i < MAX_W; i++) line_mem[i] = '0;
        send_idle_pct = 35;
        recv_idle_pct = 64;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest frame: flushes before any pixel are dropped, a few extreme
        // values in the first row, then a saturated field so the interior
        // averages to full scale. A pixel slipped into the tail is dropped.
        write_size(11'd12, 11'd12);
        add_beat(REQ_FLUSH, 8'h00);
        add_beat(REQ_FLUSH, 8'hFF);
        add_beat(REQ_PIXEL, 8'h00);
        add_beat(REQ_PIXEL, 8'hFF);
        add_beat(REQ_PIXEL, 8'h55);
        add_beat(REQ_PIXEL, 8'hAA);
        for (int i = 4; i < 144; i++) add_beat(REQ_PIXEL, 8'hFF);
        for (int i = 0; i < 26; i++) begin
            add_beat(REQ_FLUSH, 8'h00);
            if (i == 0) add_beat(REQ_PIXEL, 8'h3C);
        end
        stim_items += 170;
        settle();

        // Shrink the width in the middle of row two so the input column wraps.
        write_size(11'd20, 11'd14);
        repeat (55) add_beat(REQ_PIXEL, pick_pixel(FILL_RANDOM));
        stim_items += 55;
        settle();
        write_size(11'd12, 11'd13);
        finish_frame();
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 35 : 0;
            phase_start   = stim_items;
            while (stim_items - phase_start < 250) begin
                settle();
                write_size(CFG_DW'($urandom_range(12, 18)), CFG_DW'($urandom_range(12, 16)));
                repeat ($urandom_range(1, 2)) queue_frame(4);
            end
        end

        // Hold the output off while the sender keeps going.
        settle();
        write_size(11'd16, 11'd12);
        stall_reqs++;
        queue_frame(0);
        settle();

        // Largest width and largest height; the width is written past its limit and
        // the other size below the minimum, so the block saturates them.
        write_size(11'd2047, 11'd0);
        queue_frame(0);
        settle();
        write_size(11'd5, 11'd1024);
        queue_frame(1);
        settle();

        $display("Ran %0d input beats (%0d stimulus items), checked %0d results, %0d blurred.",
                 beats_in, stim_items, results_checked, blurred_seen);
        $display("Completed %0d frames from 12x12 up to 1024 wide and 1024 tall.", frames_seen);
        if (mismatch_count == 0) begin
            $display("tb_box_blur_5x5_stream OK");
        end else begin
            $display("tb_box_blur_5x5_stream NOT OK");
        end
        $finish;
    end

endmodule

// File: box_blur_5x5_stream.f
rtl/bb5_pkg.sv
rtl/bb5_divider.sv
rtl/box_blur_5x5_stream.sv
sim/tb_box_blur_5x5_stream.sv
